### hw/rtl/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

  // Character codes and divide-by-ten constants.
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_NINE  = 8'h39;
  localparam logic [7:0]  ASCII_MINUS = 8'h2D;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int DIGS_W     = MAX_DIGITS * DIGIT_W;
  localparam int QUEUE_DEPTH = 2;

  // One converted number: sign, digit count and the digits, most
  // significant digit in the lowest nibble.
  typedef struct packed {
    logic              neg;
    logic [3:0]        ndig;
    logic [DIGS_W-1:0] digits;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_HOLD
  } front_state_t;

endpackage

`default_nettype wire

### hw/rtl/signed_int_to_decimal_ascii_core.sv
`default_nettype none

// Channel   Direction  Handshake         Word contents
// in_       input      in_valid/stall    in_value: signed 32-bit integer
// out_      output     out_valid/stall   out_char_code, out_last, out_char_count
//
// The front takes one word and works out one decimal digit at a time in its
// divide-by-ten multiplier, keeping in_stall high until the number is queued.
// The back sends one character per cycle from its output register while
// out_stall is low, 1 to 11 characters per number; a two-entry queue lets both
// run at once, so the front can take a new number while the back still sends.
// Reset is synchronous and active low; in_stall is high while it is asserted.
// A stalled output holds its word; the front keeps working until the queue fills.

module signed_int_to_decimal_ascii_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_char_code,
  output logic                    out_last,
  output logic [3:0]              out_char_count
);

  // Entries that cross from the converting front to the emitting back.
  sitda_pkg::entry_t q_wdata;
  sitda_pkg::entry_t q_rdata;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_nonempty;

  // The front turns the magnitude into digits, least significant first,
  // and stores them so that the most significant digit ends up in front.
  sitda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sitda_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  // The back sends the sign when there is one, then the digits, and counts
  // the characters as they go out.
  sitda_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

endmodule

`default_nettype wire

### hw/rtl/sitda_front.sv
`default_nettype none

module sitda_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [31:0]  in_value,
  input  wire logic                q_full,
  output logic                     q_push,
  output sitda_pkg::entry_t        q_wdata
);

  sitda_pkg::front_state_t state_r, state_nxt;

  logic                         neg_r, neg_nxt;
  logic [31:0]                  mag_r, mag_nxt;
  logic [3:0]                   ndig_r, ndig_nxt;
  logic [sitda_pkg::DIGS_W-1:0] digs_r, digs_nxt;

  logic [63:0] prod;
  logic [31:0] quo;
  logic [3:0]  q10_lo;
  logic [3:0]  rem;
  logic        accept;
  logic        conv_done;

  // Divide by ten through a reciprocal; the remainder fits in one nibble,
  // so only the low bits of ten times the quotient are needed.
  assign prod   = 64'(mag_r) * 64'(sitda_pkg::RECIP_TEN);
  assign quo    = {3'b000, prod[63:sitda_pkg::RECIP_SHIFT]};
  assign q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign rem    = mag_r[3:0] - q10_lo;

  assign accept    = in_valid && !in_stall;
  assign conv_done = (quo == 32'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sitda_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = sitda_pkg::F_CONV;
        end
      end
      sitda_pkg::F_CONV: begin
        if (conv_done) begin
          state_nxt = q_full ? sitda_pkg::F_HOLD : sitda_pkg::F_IDLE;
        end
      end
      sitda_pkg::F_HOLD: begin
        if (!q_full) begin
          state_nxt = sitda_pkg::F_IDLE;
        end
      end
      default: state_nxt = sitda_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall = !rst_n || (state_r != sitda_pkg::F_IDLE);
    q_push   = 1'b0;
    unique case (state_r)
      sitda_pkg::F_IDLE: q_push = 1'b0;
      sitda_pkg::F_CONV: q_push = conv_done && !q_full;
      sitda_pkg::F_HOLD: q_push = !q_full;
      default:           q_push = 1'b0;
    endcase
  end

  always_comb begin
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    ndig_nxt = ndig_r;
    digs_nxt = digs_r;
    if (state_r == sitda_pkg::F_IDLE) begin
      neg_nxt  = in_value[31];
      mag_nxt  = in_value[31] ? (32'd0 - in_value) : in_value;
      ndig_nxt = 4'd0;
    end else if (state_r == sitda_pkg::F_CONV) begin
      mag_nxt  = quo;
      ndig_nxt = ndig_r + 4'd1;
      digs_nxt = {digs_r[sitda_pkg::DIGS_W-sitda_pkg::DIGIT_W-1:0], rem};
    end
  end

  assign q_wdata.neg    = neg_r;
  assign q_wdata.ndig   = ndig_nxt;
  assign q_wdata.digits = digs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitda_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    ndig_r <= ndig_nxt;
    digs_r <= digs_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/sitda_queue.sv
`default_nettype none

module sitda_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sitda_pkg::entry_t  wdata,
  output logic                    full,
  input  wire logic               pop,
  output logic                    nonempty,
  output sitda_pkg::entry_t       rdata
);

  sitda_pkg::entry_t mem_r [sitda_pkg::QUEUE_DEPTH];

  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'(sitda_pkg::QUEUE_DEPTH));
  assign nonempty = (cnt_r != 2'd0);
  assign rdata    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sitda_back.sv
`default_nettype none

module sitda_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_nonempty,
  input  wire sitda_pkg::entry_t  q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_char_code,
  output logic                    out_last,
  output logic [3:0]              out_char_count
);

  logic                         cur_valid_r, cur_valid_nxt;
  logic                         cur_sign_r, cur_sign_nxt;
  logic [sitda_pkg::DIGS_W-1:0] cur_digs_r, cur_digs_nxt;
  logic [3:0]                   cur_left_r, cur_left_nxt;
  logic [3:0]                   cur_cnt_r, cur_cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_code_r, out_code_nxt;
  logic       out_last_r, out_last_nxt;
  logic [3:0] out_cnt_r, out_cnt_nxt;

  logic       out_adv;
  logic       emit;
  logic       is_last;
  logic [7:0] char_code;

  assign out_adv   = !out_valid_r || !out_stall;
  assign emit      = out_adv && cur_valid_r;
  assign is_last   = !cur_sign_r && (cur_left_r == 4'd1);
  assign char_code = cur_sign_r ? sitda_pkg::ASCII_MINUS
                                : sitda_pkg::ASCII_ZERO + {4'h0, cur_digs_r[3:0]};
  assign q_pop     = q_nonempty && (!cur_valid_r || (emit && is_last));

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_sign_nxt  = cur_sign_r;
    cur_digs_nxt  = cur_digs_r;
    cur_left_nxt  = cur_left_r;
    cur_cnt_nxt   = cur_cnt_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_sign_nxt  = q_rdata.neg;
      cur_digs_nxt  = q_rdata.digits;
      cur_left_nxt  = q_rdata.ndig;
      cur_cnt_nxt   = 4'd0;
    end else if (emit) begin
      cur_cnt_nxt = cur_cnt_r + 4'd1;
      if (cur_sign_r) begin
        cur_sign_nxt = 1'b0;
      end else begin
        cur_digs_nxt = {4'h0, cur_digs_r[sitda_pkg::DIGS_W-1:sitda_pkg::DIGIT_W]};
        cur_left_nxt = cur_left_r - 4'd1;
      end
      if (is_last) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = char_code;
      out_last_nxt  = is_last;
      out_cnt_nxt   = cur_cnt_r + 4'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_sign_r <= cur_sign_nxt;
    cur_digs_r <= cur_digs_nxt;
    cur_left_r <= cur_left_nxt;
    cur_cnt_r  <= cur_cnt_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_code_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_cnt_r;

endmodule

`default_nettype wire

### hw/rtl/sitda_checker.sv
`default_nettype none

module sitda_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_char_code,
  input wire logic       out_last,
  input wire logic [3:0] out_char_count
);

  // A stalled word stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code)
      && $stable(out_last) && $stable(out_char_count))
    else $error("stalled output word changed");

  // Every number has between one and eleven characters.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_count >= 4'd1) && (out_char_count <= 4'd11)
      && (out_last || (out_char_count <= 4'd10)))
    else $error("character count out of range");

  // Only a minus sign or a decimal digit is ever sent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == sitda_pkg::ASCII_MINUS)
      || ((out_char_code >= sitda_pkg::ASCII_ZERO)
        && (out_char_code <= sitda_pkg::ASCII_NINE)))
    else $error("illegal character code");

  // The sign only opens a number and is never its last character.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == sitda_pkg::ASCII_MINUS)
      |-> (out_char_count == 4'd1) && !out_last)
    else $error("minus sign out of place");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_code  (out_char_code),
  .out_last       (out_last),
  .out_char_count (out_char_count)
);

`default_nettype wire
